// ----- design/glb_pkg.sv -----
// Package for the gray Laplacian binariser: sizes, register indexes,
// grey weights and the transaction and divider structs.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps

package glb_pkg;

  // Geometry limits and derived widths
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int DIM_W      = 11;
  localparam int EMIT_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int NTOT_W     = EMIT_W + 1;
  localparam int DARK_W     = 21;
  localparam int DIVD_W     = DARK_W + 7;
  localparam int DIVS_W     = NTOT_W;
  localparam int DCNT_W     = $clog2(DIVD_W);
  localparam int SUM_W      = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 63;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_THRESHOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WEIGHTS  = 3'd4;

  // Register reset values
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;
  localparam logic [DIM_W-1:0] DIM_MIN      = 11'd3;

  // Grey weights in unsigned Q0.16
  localparam logic [15:0] GRAY_W_RED   = 16'd19661;
  localparam logic [15:0] GRAY_W_GREEN = 16'd38666;
  localparam logic [15:0] GRAY_W_BLUE  = 16'd7209;

  localparam logic [7:0] PIX_WHITE   = 8'd255;
  localparam logic [6:0] PERCENT_MAX = 7'd100;
  localparam logic [DARK_W-1:0] DARK_SAT = {DARK_W{1'b1}};

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } glb_in_t;

  typedef struct packed {
    logic [7:0] out_pixel;
    logic       last_of_frame;
    logic [6:0] dark_percent;
    logic       nearly_black;
  } glb_out_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } glb_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
    logic [DIVS_W-1:0] remainder;
  } glb_div_rsp_t;

endpackage

// ----- design/glb_line_ram.sv -----
// Line store: one synchronous single-port memory holding the upper and
// middle grey lines side by side, with a registered read. Uses glb_pkg.
`timescale 1ns / 1ps

module glb_line_ram
  import glb_pkg::*;
(
  input  logic             clk,
  input  logic             rd_en,
  input  logic             wr_en,
  input  logic [COL_W-1:0] addr,
  input  logic [15:0]      wdata,
  output logic [15:0]      rdata
);

  logic [15:0] mem [MAX_WIDTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- design/glb_divider.sv -----
// Restoring radix-2 divider, one quotient bit per cycle, shared for the
// output position and the dark percentage. Uses glb_pkg.
`timescale 1ns / 1ps

module glb_divider
  import glb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  glb_div_req_t req,
  output glb_div_rsp_t rsp
);

  logic              busy;
  logic [DCNT_W-1:0] count;
  logic [DIVD_W-1:0] quo;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] divisor;
  logic              done;
  logic [DIVS_W:0]   trial;
  logic              fits;

  // Shift in the next dividend bit and test against the divisor
  assign trial = {rem, quo[DIVD_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && count == '0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
      count   <= DCNT_W'(DIVD_W - 1);
    end else if (busy) begin
      quo   <= {quo[DIVD_W-2:0], fits};
      rem   <= fits ? DIVS_W'(trial - {1'b0, divisor}) : trial[DIVS_W-1:0];
      count <= count - 1'b1;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ----- design/gray_laplacian_binarizer.sv -----
// Top level of the gray Laplacian binariser: configuration registers, the
// item sequencer, grey conversion and kernel accumulation.
// Depends on glb_pkg, glb_line_ram and glb_divider.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------
//  in       | input     | in_valid / in_ready  | in_data  (glb_in_t)
//  out      | output    | out_valid / out_ready| out_data (glb_out_t)
//  cfg      | input     | cfg_write            | cfg_index, cfg_data
//
//  One item is handled at a time. A pixel that yields no output passes
//  through accept, three grey multiply steps and the line store
//  read-modify-write. An output adds the position division on the shared
//  divider, up to nine kernel multiply-accumulate steps, a finish step and
//  the output load; the last output of a frame adds a set-up step and the
//  percentage division.
//  Reset clears control state and loads the register defaults; the line
//  store is not cleared. A finished result waits in the output register
//  while out_ready is low, and the sequencer holds until it can be loaded.

module gray_laplacian_binarizer
  import glb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  glb_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output glb_out_t              out_data,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_GRAY   = 9'b000000010,
    S_UPD    = 9'b000000100,
    S_DIVR   = 9'b000001000,
    S_MAC    = 9'b000010000,
    S_FIN    = 9'b000100000,
    S_PCTMUL = 9'b001000000,
    S_PCT    = 9'b010000000,
    S_OUT    = 9'b100000000
  } glb_state_t;

  // Configuration registers
  logic [DIM_W-1:0]      cfg_width;
  logic [DIM_W-1:0]      cfg_height;
  logic [7:0]            cfg_bin_thr;
  logic [6:0]            cfg_class_thr;
  logic [CFG_DATA_W-1:0] cfg_kernel;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width     <= WIDTH_RESET;
      cfg_height    <= HEIGHT_RESET;
      cfg_bin_thr   <= '0;
      cfg_class_thr <= '0;
      cfg_kernel    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:     cfg_width     <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:    cfg_height    <= cfg_data[DIM_W-1:0];
        REG_BIN_THRESHOLD:   cfg_bin_thr   <= cfg_data[7:0];
        REG_CLASS_THRESHOLD: cfg_class_thr <= cfg_data[6:0];
        REG_KERNEL_WEIGHTS:  cfg_kernel    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Geometry saturated to the supported range
  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;

  assign w = (cfg_width < DIM_MIN) ? DIM_MIN :
             (cfg_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : cfg_width;
  assign h = (cfg_height < DIM_MIN) ? DIM_MIN :
             (cfg_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : cfg_height;

  // Kernel weights split per tap
  logic [6:0] kw [9];

  for (genvar k = 0; k < 9; k++) begin : g_kw
    assign kw[k] = cfg_kernel[7*k +: 7];
  end

  // Sequencer state
  glb_state_t        state;
  logic [COL_W-1:0]  column;
  logic [DIM_W-1:0]  row;
  logic [EMIT_W-1:0] emitted;
  logic [DARK_W-1:0] dark;
  logic [COL_W-1:0]  col_cur;
  logic [DIM_W-1:0]  row_cur;
  glb_in_t           item;
  logic [1:0]        gray_step;
  logic [7:0]        gray_acc;
  logic [7:0]        hist [6];
  logic [7:0]        win [9];
  logic [3:0]        mac_idx;
  logic signed [SUM_W-1:0] sum;
  logic              is_drain;
  logic [NTOT_W-1:0] n_total;
  logic [7:0]        pix;
  logic              last_flag;
  logic [6:0]        pct;
  logic              nb;
  glb_div_req_t      div_req;
  glb_div_rsp_t      div_rsp;

  // Line store port
  logic             ram_rd;
  logic             ram_wr;
  logic [COL_W-1:0] ram_addr;
  logic [COL_W-1:0] col_sel;
  logic [15:0]      ram_rdata;

  assign in_ready = (state == S_IDLE);
  assign col_sel  = ({1'b0, column} >= w) ? '0 : column;
  assign ram_rd   = in_valid && in_ready && in_data.kind == KIND_PIXEL && row < h;
  assign ram_wr   = (state == S_UPD);
  assign ram_addr = (state == S_IDLE) ? col_sel : col_cur;

  glb_line_ram u_line_ram (
    .clk   (clk),
    .rd_en (ram_rd),
    .wr_en (ram_wr),
    .addr  (ram_addr),
    .wdata ({ram_rdata[7:0], gray_acc}),
    .rdata (ram_rdata)
  );

  glb_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Grey multiply, one component per cycle
  logic [15:0] gray_w;
  logic [7:0]  gray_c;
  logic [23:0] gray_prod;

  always_comb begin
    case (gray_step)
      2'd0:    begin gray_w = GRAY_W_RED;   gray_c = item.red;   end
      2'd1:    begin gray_w = GRAY_W_GREEN; gray_c = item.green; end
      default: begin gray_w = GRAY_W_BLUE;  gray_c = item.blue;  end
    endcase
  end

  assign gray_prod = {8'b0, gray_w} * {16'b0, gray_c};

  // Kernel multiply-accumulate, one tap per cycle
  logic signed [15:0] mac_prod;

  assign mac_prod = 16'($signed(kw[mac_idx])) * 16'($signed({1'b0, win[mac_idx]}));

  // Position test on the divider result
  logic [EMIT_W-1:0] out_r;
  logic [DIM_W-1:0]  out_c;
  logic              interior;

  assign out_r    = div_rsp.quotient[EMIT_W-1:0];
  assign out_c    = div_rsp.remainder[DIM_W-1:0];
  assign interior = !is_drain && out_r != '0
                    && ({1'b0, out_r} + 1'b1) < NTOT_W'(h)
                    && out_c != '0 && ({1'b0, out_c} + 1'b1) < {1'b0, w};

  // Clamped filter value and end of frame test
  logic [7:0]        val;
  logic [NTOT_W-1:0] emitted_inc;
  logic [DIM_W-1:0]  row_inc;
  logic [DIM_W-1:0]  col_inc;
  logic              out_load;

  assign val = (sum > SUM_W'(255)) ? 8'd255 : (sum < 0) ? 8'd0 : sum[7:0];
  assign emitted_inc = {1'b0, emitted} + 1'b1;
  assign row_inc     = row + 1'b1;
  assign col_inc     = {1'b0, col_cur} + 1'b1;
  assign out_load    = (state == S_OUT) && (!out_valid || out_ready);

  // Control and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      column        <= '0;
      row           <= '0;
      emitted       <= '0;
      dark          <= '0;
      out_valid     <= 1'b0;
      div_req.start <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        hist[i] <= '0;
      end
    end else begin
      // The output register empties unless a new result is loaded this cycle
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.kind == KIND_DRAIN) begin
              if (row >= h) begin
                is_drain         <= 1'b1;
                div_req.start    <= 1'b1;
                div_req.dividend <= DIVD_W'(emitted);
                div_req.divisor  <= DIVS_W'(w);
                state            <= S_DIVR;
              end
            end else if (row < h) begin
              if ({1'b0, column} >= w) begin
                // Width shrank: the column wraps onto the next row
                if (row_inc >= h) begin
                  column <= '0;
                  row    <= row_inc;
                end else begin
                  col_cur   <= '0;
                  row_cur   <= row_inc;
                  item      <= in_data;
                  gray_acc  <= '0;
                  gray_step <= '0;
                  state     <= S_GRAY;
                end
              end else begin
                col_cur   <= column;
                row_cur   <= row;
                item      <= in_data;
                gray_acc  <= '0;
                gray_step <= '0;
                state     <= S_GRAY;
              end
            end
          end
        end
        S_GRAY: begin
          gray_acc  <= gray_acc + gray_prod[23:16];
          gray_step <= gray_step + 1'b1;
          if (gray_step == 2'd2) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          // Shift the window and write the line store back
          win[0]  <= hist[0]; win[3] <= hist[1]; win[6] <= hist[2];
          win[1]  <= hist[3]; win[4] <= hist[4]; win[7] <= hist[5];
          win[2]  <= ram_rdata[15:8];
          win[5]  <= ram_rdata[7:0];
          win[8]  <= gray_acc;
          hist[0] <= hist[3];
          hist[1] <= hist[4];
          hist[2] <= hist[5];
          hist[3] <= ram_rdata[15:8];
          hist[4] <= ram_rdata[7:0];
          hist[5] <= gray_acc;
          if (col_inc >= w) begin
            column <= '0;
            row    <= row_cur + 1'b1;
          end else begin
            column <= col_inc[COL_W-1:0];
            row    <= row_cur;
          end
          if (row_cur != '0 && (row_cur > DIM_W'(1) || col_cur != '0)) begin
            is_drain         <= 1'b0;
            div_req.start    <= 1'b1;
            div_req.dividend <= DIVD_W'(emitted);
            div_req.divisor  <= DIVS_W'(w);
            state            <= S_DIVR;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIVR: begin
          // The start pulse lasts a single cycle
          div_req.start <= 1'b0;
          if (div_rsp.done) begin
            n_total <= NTOT_W'(w) * NTOT_W'(h);
            sum     <= '0;
            mac_idx <= '0;
            state   <= interior ? S_MAC : S_FIN;
          end
        end
        S_MAC: begin
          sum     <= sum + SUM_W'(mac_prod);
          mac_idx <= mac_idx + 1'b1;
          if (mac_idx == 4'd8) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          pix       <= (val > cfg_bin_thr) ? PIX_WHITE : 8'd0;
          last_flag <= emitted_inc >= n_total;
          pct       <= '0;
          nb        <= 1'b0;
          if (val <= cfg_bin_thr && dark != DARK_SAT) begin
            dark <= dark + 1'b1;
          end
          emitted <= emitted_inc[EMIT_W-1:0];
          state   <= (emitted_inc >= n_total) ? S_PCTMUL : S_OUT;
        end
        S_PCTMUL: begin
          div_req.start    <= 1'b1;
          div_req.dividend <= DIVD_W'(dark) * DIVD_W'(PERCENT_MAX);
          div_req.divisor  <= n_total;
          state            <= S_PCT;
        end
        S_PCT: begin
          div_req.start <= 1'b0;
          if (div_rsp.done) begin
            if (div_rsp.quotient > DIVD_W'(PERCENT_MAX)) begin
              pct <= PERCENT_MAX;
              nb  <= PERCENT_MAX > cfg_class_thr;
            end else begin
              pct <= div_rsp.quotient[6:0];
              nb  <= div_rsp.quotient[6:0] > cfg_class_thr;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_valid               <= 1'b1;
            out_data.out_pixel      <= pix;
            out_data.last_of_frame  <= last_flag;
            out_data.dark_percent   <= pct;
            out_data.nearly_black   <= nb;
            if (last_flag) begin
              column  <= '0;
              row     <= '0;
              emitted <= '0;
              dark    <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_restart: assert property (@(posedge clk) disable iff (rst)
    out_load && last_flag |=> (emitted == '0 && row == '0 && dark == '0))
    else $error("frame counters not restarted after the last transaction");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.dark_percent <= PERCENT_MAX)
    else $error("dark percentage above 100");

  a_pct_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_of_frame |->
      (out_data.dark_percent == '0 && !out_data.nearly_black))
    else $error("frame statistics on a transaction that is not last");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIVR || state == S_PCT))
    else $error("divider finished while the sequencer was not waiting");
`endif

endmodule
